>>> rtl/keyframe_position_lerp_defines.svh
// ----------------------------------------------------------------------------
// Keyframe position lerp assertion macros
// Shared property wrappers. Each expects clk and rst in the using scope.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_POSITION_LERP_DEFINES_SVH
`define KEYFRAME_POSITION_LERP_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define KPL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside of reset.
`define KPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/kpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe position lerp package
// Sizes, codes and the command and status words between controller and
// datapath.
// ----------------------------------------------------------------------------
package kpl_pkg;

  // Track size and word widths.
  localparam int KEYS      = 64;
  localparam int ADDR_W    = $clog2(KEYS);
  localparam int CNT_W     = 7;
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int COMPS     = 3;
  localparam int DIV_CNT_W = $clog2(FRAC_BITS);
  localparam int COMP_W    = 2;

  // Request codes.
  typedef enum logic [0:0] {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } kpl_req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_INTERP   = 2'd0,
    STAT_HELD     = 2'd1,
    STAT_ZERO_LEN = 2'd2
  } kpl_status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHK,
    S_HOLD,
    S_DIV,
    S_MUL,
    S_ADD,
    S_EMIT
  } kpl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              key_wr;
    logic              ld_query;
    logic              ld_t2;
    logic              ld_hold;
    logic              div_init;
    logic              ld_diff;
    logic              div_step;
    logic              mul;
    logic              add;
    logic [COMP_W-1:0] comp;
    logic [ADDR_W-1:0] rd_addr;
  } kpl_cmd_t;

  // Compare flags from the datapath to the controller.
  typedef struct packed {
    logic qtime_lt_rd;
    logic t2_le_rd;
  } kpl_sts_t;

endpackage

>>> rtl/kpl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe position lerp datapath
// Key memories, restoring divider for the blend factor, and one shared
// multiplier for the three components.
// ----------------------------------------------------------------------------
`include "keyframe_position_lerp_defines.svh"

module kpl_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  kpl_pkg::kpl_cmd_t          cmd,
  output kpl_pkg::kpl_sts_t          sts,
  input  logic [kpl_pkg::ADDR_W-1:0] key_slot,
  input  logic [31:0]                key_time,
  input  logic signed [31:0]         key_x,
  input  logic signed [31:0]         key_y,
  input  logic signed [31:0]         key_z,
  input  logic [31:0]                query_time,
  output logic signed [31:0]         pos_x,
  output logic signed [31:0]         pos_y,
  output logic signed [31:0]         pos_z
);
  import kpl_pkg::*;

  logic [DATA_W-1:0]          time_mem [KEYS];
  logic [COMPS*DATA_W-1:0]    vec_mem  [KEYS];
  logic [DATA_W-1:0]          time_q;
  logic [COMPS*DATA_W-1:0]    vec_q;
  logic signed [DATA_W-1:0]   vq    [COMPS];
  logic [DATA_W-1:0]          qtime;
  logic [DATA_W-1:0]          t2;
  logic [DATA_W-1:0]          rem;
  logic [DATA_W-1:0]          dvs;
  logic [FRAC_BITS-1:0]       quo;
  logic [DATA_W:0]            rem_sh;
  logic signed [DATA_W-1:0]   start [COMPS];
  logic signed [DATA_W:0]     diff  [COMPS];
  logic signed [DATA_W+FRAC_BITS+1:0] prod;
  logic signed [DATA_W-1:0]   pos   [COMPS];

  // Key memories: one write port from the input word, one registered read.
  always_ff @(posedge clk) begin
    if (cmd.key_wr) begin
      time_mem[key_slot] <= key_time;
      vec_mem[key_slot]  <= {key_z, key_y, key_x};
    end
    time_q <= time_mem[cmd.rd_addr];
    vec_q  <= vec_mem[cmd.rd_addr];
  end

  // Split the read vector into its components.
  always_comb begin
    for (int c = 0; c < COMPS; c++) begin
      vq[c] = vec_q[c*DATA_W +: DATA_W];
    end
  end

  // Compare flags for the scan and the segment checks.
  assign sts.qtime_lt_rd = (qtime < time_q);
  assign sts.t2_le_rd    = (t2 <= time_q);

  // One restoring step: shift the remainder and try the divisor.
  assign rem_sh = {rem, 1'b0};

  // Query time, segment end time and the divider.
  always_ff @(posedge clk) begin
    if (cmd.ld_query) begin
      qtime <= query_time;
    end
    if (cmd.ld_t2) begin
      t2 <= time_q;
    end
    if (cmd.div_init) begin
      rem <= qtime - time_q;
      dvs <= t2 - time_q;
      quo <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= DATA_W'(rem_sh - {1'b0, dvs});
        quo <= {quo[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DATA_W-1:0];
        quo <= {quo[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  // Start vector and component deltas, taken while the divider runs.
  always_ff @(posedge clk) begin
    for (int c = 0; c < COMPS; c++) begin
      if (cmd.div_init) begin
        start[c] <= vq[c];
      end
      if (cmd.ld_diff) begin
        diff[c] <= {vq[c][DATA_W-1], vq[c]} - {start[c][DATA_W-1], start[c]};
      end
    end
  end

  // Shared multiplier, then the floored add of the scaled delta, or a held key.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= diff[cmd.comp] * $signed({1'b0, quo});
    end
    if (cmd.add) begin
      pos[cmd.comp] <= start[cmd.comp] + prod[DATA_W+FRAC_BITS-1:FRAC_BITS];
    end else if (cmd.ld_hold) begin
      for (int c = 0; c < COMPS; c++) begin
        pos[c] <= vq[c];
      end
    end
  end

  assign pos_x = pos[0];
  assign pos_y = pos[1];
  assign pos_z = pos[2];

  // The remainder stays below the divisor for the whole division.
  `KPL_ASSERT_IMPL(a_rem_below_dvs, cmd.div_step, rem < dvs, "divider remainder reached divisor")

endmodule

>>> rtl/kpl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe position lerp controller
// Holds the key count register and sequences scan, segment checks,
// division and the per-component multiply.
// ----------------------------------------------------------------------------
`include "keyframe_position_lerp_defines.svh"

module kpl_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [0:0]                 req_type,
  input  logic                       cfg_we,
  input  logic [kpl_pkg::CNT_W-1:0]  cfg_data,
  output kpl_pkg::kpl_cmd_t          cmd,
  input  kpl_pkg::kpl_sts_t          sts,
  output logic                       done,
  output logic [kpl_pkg::ADDR_W-1:0] segment,
  output logic [1:0]                 status
);
  import kpl_pkg::*;

  kpl_state_t            state, state_next;
  kpl_status_t           stat, stat_next;
  logic [CNT_W-1:0]      key_count;
  logic [ADDR_W-1:0]     last_idx;
  logic [ADDR_W-1:0]     idx, idx_next;
  logic [ADDR_W-1:0]     seg, seg_next;
  logic [DIV_CNT_W-1:0]  div_cnt, div_cnt_next;
  logic [COMP_W-1:0]     comp, comp_next;

  // Key count register and the index of the last key in use.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= CNT_W'(1);
    end else if (cfg_we) begin
      key_count <= cfg_data;
    end
  end

  always_comb begin
    if (key_count == '0) begin
      last_idx = '0;
    end else if (key_count > CNT_W'(KEYS)) begin
      last_idx = ADDR_W'(KEYS - 1);
    end else begin
      last_idx = ADDR_W'(key_count - CNT_W'(1));
    end
  end

  // State and sequencing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      stat    <= STAT_INTERP;
      idx     <= '0;
      seg     <= '0;
      div_cnt <= '0;
      comp    <= '0;
    end else begin
      state   <= state_next;
      stat    <= stat_next;
      idx     <= idx_next;
      seg     <= seg_next;
      div_cnt <= div_cnt_next;
      comp    <= comp_next;
    end
  end

  assign busy    = (state != S_IDLE);
  assign done    = (state == S_EMIT);
  assign segment = seg;
  assign status  = stat;

  // Next state and datapath commands.
  always_comb begin
    state_next   = state;
    stat_next    = stat;
    idx_next     = idx;
    seg_next     = seg;
    div_cnt_next = div_cnt;
    comp_next    = comp;
    cmd          = '0;
    cmd.rd_addr  = idx;
    cmd.comp     = comp;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_WRITE) begin
            cmd.key_wr = 1'b1;
          end else begin
            cmd.ld_query = 1'b1;
            if (last_idx == '0) begin
              seg_next    = '0;
              stat_next   = STAT_HELD;
              cmd.rd_addr = '0;
              state_next  = S_HOLD;
            end else begin
              idx_next    = ADDR_W'(1);
              cmd.rd_addr = ADDR_W'(1);
              state_next  = S_SCAN;
            end
          end
        end
      end

      // The read data holds the time of key idx, the end of segment idx-1.
      S_SCAN: begin
        if (sts.qtime_lt_rd) begin
          seg_next    = idx - ADDR_W'(1);
          cmd.ld_t2   = 1'b1;
          cmd.rd_addr = idx - ADDR_W'(1);
          state_next  = S_CHK;
        end else if (idx == last_idx) begin
          seg_next    = idx;
          stat_next   = STAT_HELD;
          cmd.rd_addr = idx;
          state_next  = S_HOLD;
        end else begin
          idx_next    = idx + ADDR_W'(1);
          cmd.rd_addr = idx + ADDR_W'(1);
        end
      end

      // The read data holds the start key of the chosen segment.
      S_CHK: begin
        if (sts.t2_le_rd) begin
          stat_next   = STAT_ZERO_LEN;
          cmd.ld_hold = 1'b1;
          state_next  = S_EMIT;
        end else if (sts.qtime_lt_rd) begin
          stat_next   = STAT_HELD;
          cmd.ld_hold = 1'b1;
          state_next  = S_EMIT;
        end else begin
          stat_next    = STAT_INTERP;
          cmd.div_init = 1'b1;
          cmd.rd_addr  = seg + ADDR_W'(1);
          div_cnt_next = '0;
          state_next   = S_DIV;
        end
      end

      S_HOLD: begin
        cmd.ld_hold = 1'b1;
        state_next  = S_EMIT;
      end

      // One quotient bit per cycle; the end key arrives in the first one.
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.ld_diff  = (div_cnt == '0);
        if (div_cnt == DIV_CNT_W'(FRAC_BITS - 1)) begin
          comp_next  = '0;
          state_next = S_MUL;
        end else begin
          div_cnt_next = div_cnt + DIV_CNT_W'(1);
        end
      end

      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end

      S_ADD: begin
        cmd.add = 1'b1;
        if (comp == COMP_W'(COMPS - 1)) begin
          state_next = S_EMIT;
        end else begin
          comp_next  = comp + COMP_W'(1);
          state_next = S_MUL;
        end
      end

      S_EMIT: begin
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencing checks.
  `KPL_ASSERT_IMPL(a_scan_in_range, state == S_SCAN, idx <= last_idx && idx != '0, "scan index out of range")
  `KPL_ASSERT_NEXT(a_query_busy, start && !busy && req_type == REQ_QUERY, busy, "query accepted but block idle")
  `KPL_ASSERT_NEXT(a_emit_once, state == S_EMIT, state == S_IDLE && !done, "result word not single cycle")

endmodule

>>> rtl/keyframe_position_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe position lerp
// Track of up to 64 position keys with linear interpolation in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   An input word is taken when start is high and busy is low. A key write
//   (req_type 0) stores key_time and key_x/y/z in slot key_slot in that same
//   cycle and gives no result; the block stays ready.
//   A query (req_type 1) raises busy and later returns one result word on
//   pos_x/y/z, segment and status, marked by done for exactly one cycle.
//   The receiver cannot stall; the result is assured only in the done cycle.
//   Query sequence: a single-key track loads the held key, then raises done.
//   Otherwise the scan reads one key time per cycle from the key memory read
//   port, through at most key_count - 1 keys; then a held result loads the
//   held key, and an interpolation needs one check, 16 divider steps (one
//   quotient bit each) and a multiply and an add per component through the
//   shared multiplier, then done. A new query can start the cycle after done.
//   The user writes key_count via cfg_we/cfg_data only while idle; the block
//   does not check it. Reset sets key_count to 1 and the controller to idle;
//   key slots are not cleared and must be written before they are read.
// ----------------------------------------------------------------------------
module keyframe_position_lerp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [0:0]                 req_type,
  input  logic [kpl_pkg::ADDR_W-1:0] key_slot,
  input  logic [31:0]                key_time,
  input  logic signed [31:0]         key_x,
  input  logic signed [31:0]         key_y,
  input  logic signed [31:0]         key_z,
  input  logic [31:0]                query_time,
  input  logic                       cfg_we,
  input  logic [kpl_pkg::CNT_W-1:0]  cfg_data,
  output logic                       done,
  output logic signed [31:0]         pos_x,
  output logic signed [31:0]         pos_y,
  output logic signed [31:0]         pos_z,
  output logic [kpl_pkg::ADDR_W-1:0] segment,
  output logic [1:0]                 status
);
  import kpl_pkg::*;

  kpl_cmd_t cmd;
  kpl_sts_t sts;

  // Sequencer and configuration register.
  kpl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .done     (done),
    .segment  (segment),
    .status   (status)
  );

  // Key storage and arithmetic.
  kpl_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .key_slot   (key_slot),
    .key_time   (key_time),
    .key_x      (key_x),
    .key_y      (key_y),
    .key_z      (key_z),
    .query_time (query_time),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z)
  );

endmodule
